// File: sv/assert_macros.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// File: sv/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the EDF task scheduler: task table entry,
// controller command/status bundles, function and event codes.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int DEF_MAX_TASKS = 8;

    // input function codes
    localparam logic FN_LOAD = 1'b0;
    localparam logic FN_TICK = 1'b1;

    typedef enum logic [1:0] {
        EV_CONT   = 2'd0,
        EV_START  = 2'd1,
        EV_SWITCH = 2'd2,
        EV_IDLE   = 2'd3
    } t_event;

    typedef struct packed {
        logic [15:0] exec;
        logic [15:0] period;
        logic [15:0] total;
        logic [15:0] jdone;
        logic [31:0] rel;
        logic [15:0] rem;
    } t_entry;

    typedef struct packed {
        logic idle;    // waiting for a beat, capture inputs
        logic load;    // write one table entry
        logic scan;    // read next table entry
        logic calc;    // first half of the job update
        logic commit;  // write back and update counters
        logic report;  // present the result
    } t_cmd;

    typedef struct packed {
        logic n_zero;     // no tasks in use
        logic scan_last;  // scan pointer sits on the last task in use
    } t_status;

endpackage

// File: sv/edf_ctrl.sv
// ----------------------------------------------------------------------------
// edf_ctrl
// Sequencer of the scheduler: steps the datapath through load, table scan,
// job update and report.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edf_ctrl
    import edf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_func,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_CALC,
        S_COMMIT,
        S_REPORT
    } t_state;

    localparam t_cmd CMD_IDLE = '{idle: 1'b1, default: 1'b0};

    t_state r_state;
    t_cmd   r_cmd;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_cmd <= '0;
            case (r_state)
                S_IDLE: begin
                    r_cmd.idle <= 1'b1;
                    if (i_start) begin
                        r_busy     <= 1'b1;
                        r_cmd.idle <= 1'b0;
                        if (i_func == FN_LOAD) begin
                            r_state    <= S_LOAD;
                            r_cmd.load <= 1'b1;
                        end else if (i_status.n_zero) begin
                            r_state    <= S_CALC;
                            r_cmd.calc <= 1'b1;
                        end else begin
                            r_state    <= S_SCAN;
                            r_cmd.scan <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (i_status.scan_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cmd.scan <= 1'b1;
                    end
                end
                // last entry read is compared in this cycle
                S_DRAIN: begin
                    r_state    <= S_CALC;
                    r_cmd.calc <= 1'b1;
                end
                S_CALC: begin
                    r_state      <= S_COMMIT;
                    r_cmd.commit <= 1'b1;
                end
                S_COMMIT: begin
                    r_state      <= S_REPORT;
                    r_cmd.report <= 1'b1;
                end
                S_LOAD: begin
                    r_state      <= S_REPORT;
                    r_cmd.report <= 1'b1;
                end
                S_REPORT: begin
                    r_state    <= S_IDLE;
                    r_cmd.idle <= 1'b1;
                    r_busy     <= 1'b0;
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_cmd.idle <= 1'b1;
                    r_busy     <= 1'b0;
                end
            endcase
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = r_busy;

    `ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, i_start && !r_busy, r_busy)
    `ASSERT_IMPL(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(r_cmd))
    `ASSERT_IMPL(a_idle_cmd_not_busy, i_clk, i_rst_n, r_cmd.idle, !r_busy)

endmodule

// File: sv/edf_dpath.sv
// ----------------------------------------------------------------------------
// edf_dpath
// Scheduler datapath: task table memory, deadline comparator used once per
// scanned entry, job update, counters and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edf_dpath
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic [2:0]  i_task_index,
    input  logic [15:0] i_exec_time,
    input  logic [15:0] i_period,
    input  logic [15:0] i_job_count,
    output logic        o_strobe,
    output logic [2:0]  o_running_task,
    output logic [1:0]  o_event_res,
    output logic        o_job_finished,
    output logic        o_deadline_missed,
    output logic [15:0] o_job_wait,
    output logic [15:0] o_miss_count,
    output logic        o_all_done
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    // task table
    t_entry r_mem [MAX_TASKS];
    t_entry r_q;

    // captured beat
    logic [2:0]  r_in_idx;
    logic [15:0] r_in_exec;
    logic [15:0] r_in_period;
    logic [15:0] r_in_jobs;

    logic [3:0]           r_task_count;
    logic [MAX_TASKS-1:0] r_done;
    logic [31:0]          r_cur_time;
    logic [IW-1:0]        r_cur_task;
    logic                 r_cur_valid;
    logic [15:0]          r_misses;

    // scan
    logic [IW-1:0] r_cnt;
    logic          r_eval_vld;
    logic [IW-1:0] r_eval_idx;
    logic          r_found;
    logic [IW-1:0] r_best_idx;
    logic [32:0]   r_best_dl;
    t_entry        r_best;

    // job update
    logic [15:0] r_rem_new;
    logic        r_fin;
    logic [32:0] r_base;
    logic [31:0] r_rel_next;
    logic [32:0] r_finish;
    t_event      r_evt;
    logic        r_last_job;
    logic [15:0] r_jdone_inc;

    // pending result
    logic [2:0]  r_res_task;
    t_event      r_res_evt;
    logic        r_res_fin;
    logic        r_res_miss;
    logic [15:0] r_res_wait;

    logic        r_strobe;
    logic [2:0]  r_o_task;
    logic [1:0]  r_o_evt;
    logic        r_o_fin;
    logic        r_o_miss;
    logic [15:0] r_o_wait;
    logic [15:0] r_o_misses;
    logic        r_o_all_done;

    logic [CW-1:0] tasks_used;
    logic [IW-1:0] last_addr;
    logic          load_ok;
    logic [IW-1:0] load_addr;
    logic [32:0]   dl;
    logic          elig;
    logic          better;
    logic          take;
    logic          miss;
    logic [32:0]   wait_diff;
    logic [15:0]   wait_sat;
    logic          all_done;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    always_comb begin
        if (int'(r_task_count) > MAX_TASKS) begin
            tasks_used = CW'(MAX_TASKS);
        end else begin
            tasks_used = CW'(r_task_count);
        end
    end

    assign last_addr          = IW'(tasks_used - CW'(1));
    assign o_status.n_zero    = (tasks_used == '0);
    assign o_status.scan_last = (r_cnt == last_addr);

    assign load_ok   = int'(r_in_idx) < MAX_TASKS;
    assign load_addr = IW'(r_in_idx);

    // candidate compare against best so far
    assign dl   = {1'b0, r_q.rel} + {17'd0, r_q.period};
    assign elig = r_eval_vld && !r_done[r_eval_idx] && (r_q.rel <= r_cur_time);

    always_comb begin
        better = 1'b0;
        if (!r_found) begin
            better = 1'b1;
        end else if (dl != r_best_dl) begin
            better = dl < r_best_dl;
        end else if (r_cur_valid && r_cur_task == r_best_idx) begin
            better = 1'b0;
        end else if (r_cur_valid && r_cur_task == r_eval_idx) begin
            better = 1'b1;
        end else begin
            better = r_q.period < r_best.period;
        end
    end

    assign take = elig && better;

    assign miss      = r_fin && (r_finish > r_best_dl);
    assign wait_diff = r_finish - r_base;

    always_comb begin
        if (r_finish <= r_base) begin
            wait_sat = 16'd0;
        end else if (wait_diff > 33'h0_0000_FFFF) begin
            wait_sat = 16'hFFFF;
        end else begin
            wait_sat = wait_diff[15:0];
        end
    end

    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (i < int'(tasks_used) && !r_done[i]) begin
                all_done = 1'b0;
            end
        end
    end

    always_comb begin
        wr_data = r_best;
        if (i_cmd.load) begin
            wr_en         = load_ok;
            wr_addr       = load_addr;
            wr_data.exec   = r_in_exec;
            wr_data.period = r_in_period;
            wr_data.total  = r_in_jobs;
            wr_data.jdone  = 16'd0;
            wr_data.rel    = 32'd0;
            wr_data.rem    = r_in_exec;
        end else begin
            wr_en   = i_cmd.commit && r_found;
            wr_addr = r_best_idx;
            if (r_fin) begin
                wr_data.jdone = r_jdone_inc;
                wr_data.rel   = r_rel_next;
                wr_data.rem   = r_best.exec;
            end else begin
                wr_data.rem   = r_rem_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.scan) begin
            r_q <= r_mem[r_cnt];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.idle) begin
            r_in_idx    <= i_task_index;
            r_in_exec   <= i_exec_time;
            r_in_period <= i_period;
            r_in_jobs   <= i_job_count;
        end
        if (i_cmd.scan) begin
            r_eval_idx <= r_cnt;
        end
        if (take) begin
            r_best_idx <= r_eval_idx;
            r_best_dl  <= dl;
            r_best     <= r_q;
        end
        if (i_cmd.calc) begin
            r_rem_new   <= (r_best.rem != 16'd0) ? r_best.rem - 16'd1 : 16'd0;
            r_fin       <= (r_best.rem <= 16'd1);
            r_base      <= {1'b0, r_best.rel} + {17'd0, r_best.exec};
            r_rel_next  <= r_best.rel + {16'd0, r_best.period};
            r_finish    <= {1'b0, r_cur_time} + 33'd1;
            r_last_job  <= ({1'b0, r_best.jdone} + 17'd1) >= {1'b0, r_best.total};
            r_jdone_inc <= r_best.jdone + 16'd1;
            if (r_cur_valid && r_cur_task == r_best_idx) begin
                r_evt <= EV_CONT;
            end else if (r_best.rem == r_best.exec) begin
                r_evt <= EV_START;
            end else begin
                r_evt <= EV_SWITCH;
            end
        end
        if (i_cmd.load || (i_cmd.commit && !r_found)) begin
            r_res_task <= 3'd0;
            r_res_evt  <= EV_IDLE;
            r_res_fin  <= 1'b0;
            r_res_miss <= 1'b0;
            r_res_wait <= 16'd0;
        end else if (i_cmd.commit) begin
            r_res_task <= 3'(r_best_idx);
            r_res_evt  <= r_evt;
            r_res_fin  <= r_fin;
            r_res_miss <= miss;
            r_res_wait <= r_fin ? wait_sat : 16'd0;
        end
        if (i_cmd.report) begin
            r_o_task     <= r_res_task;
            r_o_evt      <= r_res_evt;
            r_o_fin      <= r_res_fin;
            r_o_miss     <= r_res_miss;
            r_o_wait     <= r_res_wait;
            r_o_misses   <= r_misses;
            r_o_all_done <= all_done;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= 4'd1;
            r_done       <= '1;
            r_cur_time   <= 32'd0;
            r_cur_task   <= '0;
            r_cur_valid  <= 1'b0;
            r_misses     <= 16'd0;
            r_cnt        <= '0;
            r_eval_vld   <= 1'b0;
            r_found      <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_task_count <= i_cfg_wr_data;
            end
            r_eval_vld <= i_cmd.scan;
            r_strobe   <= i_cmd.report;
            if (i_cmd.idle) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cnt <= r_cnt + IW'(1);
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load && load_ok) begin
                r_done[load_addr] <= (r_in_jobs == 16'd0);
                if (r_cur_valid && r_cur_task == load_addr) begin
                    r_cur_valid <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                if (r_cur_time != 32'hFFFF_FFFF) begin
                    r_cur_time <= r_cur_time + 32'd1;
                end
                if (r_found) begin
                    r_cur_task  <= r_best_idx;
                    r_cur_valid <= !r_fin;
                    if (r_fin) begin
                        r_done[r_best_idx] <= r_last_job;
                    end
                    if (miss && r_misses != 16'hFFFF) begin
                        r_misses <= r_misses + 16'd1;
                    end
                end else begin
                    r_cur_valid <= 1'b0;
                end
            end
        end
    end

    assign o_strobe          = r_strobe;
    assign o_running_task    = r_o_task;
    assign o_event_res       = r_o_evt;
    assign o_job_finished    = r_o_fin;
    assign o_deadline_missed = r_o_miss;
    assign o_job_wait        = r_o_wait;
    assign o_miss_count      = r_o_misses;
    assign o_all_done        = r_o_all_done;

    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_strobe, !r_strobe)
    `ASSERT_IMPL(a_miss_on_finish, i_clk, i_rst_n, r_strobe && r_o_miss, r_o_fin)
    `ASSERT_NEXT(a_misses_hold, i_clk, i_rst_n, !i_cmd.commit, $stable(r_misses))

endmodule

// File: sv/edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// edf_task_scheduler
// Preemptive earliest-deadline-first scheduler for periodic tasks, one time
// tick per tick beat.
// ----------------------------------------------------------------------------
// Usage:
//   A beat is taken when start is high and busy is low. i_func selects a
//   task load (i_task_index, i_exec_time, i_period, i_job_count) or a tick.
//   The task count register is written through i_cfg_wr_en/i_cfg_wr_data;
//   the user must write it only while the block is idle; no check enforces it.
//   Every beat gives one result, shown for a single cycle with o_strobe;
//   the receiver cannot stall it, so nothing is held back.
//   A load writes its table entry and then reports; its result is shown in
//   the cycle in which the next beat can be taken. A tick scans the task
//   table one entry a cycle through the table memory's single read port,
//   then passes through compare drain, job update, write-back and report;
//   its result likewise comes in the cycle in which the next beat can be
//   taken, and with no tasks in use the scan and the drain are skipped.
//   Reset (synchronous, active low) clears time, counters and the running
//   task, sets the task count to 1 and marks every table slot as finished;
//   table is written by loads and write-backs only; no clearing pass runs.
// ----------------------------------------------------------------------------
module edf_task_scheduler
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [2:0]  i_task_index,
    input  logic [15:0] i_exec_time,
    input  logic [15:0] i_period,
    input  logic [15:0] i_job_count,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    output logic        o_strobe,
    output logic [2:0]  o_running_task,
    output logic [1:0]  o_event_res,
    output logic        o_job_finished,
    output logic        o_deadline_missed,
    output logic [15:0] o_job_wait,
    output logic [15:0] o_miss_count,
    output logic        o_all_done
);

    t_cmd    cmd;
    t_status status;

    edf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    edf_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_task_index      (i_task_index),
        .i_exec_time       (i_exec_time),
        .i_period          (i_period),
        .i_job_count       (i_job_count),
        .o_strobe          (o_strobe),
        .o_running_task    (o_running_task),
        .o_event_res       (o_event_res),
        .o_job_finished    (o_job_finished),
        .o_deadline_missed (o_deadline_missed),
        .o_job_wait        (o_job_wait),
        .o_miss_count      (o_miss_count),
        .o_all_done        (o_all_done)
    );

endmodule
